/* design/scd_pkg.sv */
// Shared types, constants and the sequencer program for the seconds to
// calendar date converter. No dependencies.
package scd_pkg;

  localparam int unsigned SecondsW = 32;
  localparam int unsigned YearW    = 12;
  localparam int unsigned PcW      = 4;
  localparam int unsigned DaysW    = 16;
  localparam int unsigned MulAW    = 25;  // multiplier operand after the pre-shift
  localparam int unsigned RecipW   = 26;
  localparam int unsigned ProdW    = MulAW + RecipW;

  localparam logic [YearW-1:0] BASE_YEAR_RESET = 12'd2000;
  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [16:0] SECS_PER_MIN  = 17'd60;
  localparam logic [YearW-1:0] GREG_CYCLE = 12'd400;
  localparam logic [YearW-1:0] GREG_LAST  = 12'd399;
  localparam logic [3:0] LAST_MONTH = 4'd11;
  localparam logic [3:0] FEBRUARY   = 4'd1;
  localparam logic [3:0] JULY       = 4'd6;

  // Rounded-up reciprocals: (x * RECIP) >> post equals x / divisor exactly
  // over the whole range of x that reaches each division.
  localparam logic [RecipW-1:0] RECIP_DAY  = 26'd50903317;  // 2^35 / 675, x = seconds >> 7
  localparam logic [RecipW-1:0] RECIP_HOUR = 26'd149131;    // 2^29 / 3600
  localparam logic [RecipW-1:0] RECIP_MIN  = 26'd4370;      // 2^18 / 60

  typedef struct packed {
    logic [SecondsW-1:0] seconds;
  } in_word_t;

  typedef struct packed {
    logic [YearW-1:0] year;
    logic [3:0]       month;
    logic [4:0]       day;
    logic [4:0]       hour;
    logic [5:0]       minute;
    logic [5:0]       second;
  } out_word_t;

  typedef enum logic [2:0] {
    OP_WAIT,   // take an input word
    OP_MODY,   // reduce the base year modulo 400
    OP_DIVQ,   // quotient by reciprocal multiply
    OP_DIVR,   // remainder by multiply back and subtract
    OP_YEAR,   // consume one year of days
    OP_MONTH,  // consume one month of days
    OP_OUT     // hand the result to the output register
  } op_t;

  typedef enum logic [1:0] {
    DSEL_DAY,
    DSEL_HOUR,
    DSEL_MIN
  } dsel_t;

  typedef struct packed {
    op_t         op;
    dsel_t       dsel;
    logic        last;     // return to step zero when this step is done
  } ctrl_t;

  typedef struct packed {
    logic [2:0]        pre;    // right shift ahead of the multiply
    logic [RecipW-1:0] recip;  // rounded-up reciprocal
    logic [5:0]        post;   // right shift after the multiply
    logic [16:0]       dvsr;   // the divisor itself
  } div_const_t;

  function automatic ctrl_t prog_rom(input logic [PcW-1:0] pc);
    ctrl_t c;
    c = '{op: OP_WAIT, dsel: DSEL_DAY, last: 1'b0};
    case (pc)
      4'd0:  c = '{op: OP_WAIT,  dsel: DSEL_DAY,  last: 1'b0};
      4'd1:  c = '{op: OP_MODY,  dsel: DSEL_DAY,  last: 1'b0};
      4'd2:  c = '{op: OP_DIVQ,  dsel: DSEL_DAY,  last: 1'b0};
      4'd3:  c = '{op: OP_DIVR,  dsel: DSEL_DAY,  last: 1'b0};
      4'd4:  c = '{op: OP_DIVQ,  dsel: DSEL_HOUR, last: 1'b0};
      4'd5:  c = '{op: OP_DIVR,  dsel: DSEL_HOUR, last: 1'b0};
      4'd6:  c = '{op: OP_DIVQ,  dsel: DSEL_MIN,  last: 1'b0};
      4'd7:  c = '{op: OP_DIVR,  dsel: DSEL_MIN,  last: 1'b0};
      4'd8:  c = '{op: OP_YEAR,  dsel: DSEL_DAY,  last: 1'b0};
      4'd9:  c = '{op: OP_MONTH, dsel: DSEL_DAY,  last: 1'b0};
      4'd10: c = '{op: OP_OUT,   dsel: DSEL_DAY,  last: 1'b1};
      default: c = '{op: OP_WAIT, dsel: DSEL_DAY, last: 1'b0};
    endcase
    return c;
  endfunction

  function automatic div_const_t div_const(input dsel_t d);
    div_const_t c;
    c = '{pre: 3'd7, recip: RECIP_DAY, post: 6'd35, dvsr: SECS_PER_DAY};
    unique case (d)
      DSEL_DAY:  c = '{pre: 3'd7, recip: RECIP_DAY,  post: 6'd35, dvsr: SECS_PER_DAY};
      DSEL_HOUR: c = '{pre: 3'd0, recip: RECIP_HOUR, post: 6'd29, dvsr: SECS_PER_HOUR};
      DSEL_MIN:  c = '{pre: 3'd0, recip: RECIP_MIN,  post: 6'd18, dvsr: SECS_PER_MIN};
      default:   c = '{pre: 3'd7, recip: RECIP_DAY,  post: 6'd35, dvsr: SECS_PER_DAY};
    endcase
    return c;
  endfunction

  function automatic logic [4:0] days_in_month(input logic leap, input logic [3:0] m);
    logic [3:0] k;
    logic [4:0] d;
    k = (m > JULY) ? m - 4'd1 : m;
    d = k[0] ? 5'd30 : 5'd31;
    if (m == FEBRUARY) d = leap ? 5'd29 : 5'd28;
    return d;
  endfunction

endpackage

/* design/scd_in_if.sv */
// Input channel of the date converter: valid, ready and one seconds word.
// Depends on scd_pkg.
interface scd_in_if;
  logic              valid;
  logic              ready;
  scd_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/scd_out_if.sv */
// Result channel of the date converter: valid, ready and one date word.
// Depends on scd_pkg.
interface scd_out_if;
  logic               valid;
  logic               ready;
  scd_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/seconds_to_calendar_date_core.sv */
// Top level of the seconds to calendar date converter.
// Depends on scd_pkg, scd_in_if and scd_out_if.
//
// Usage:
//   in_chan  carries one 32-bit seconds word; it is taken when valid and
//            ready are both high. ready is high only at the first program
//            step, so one word is converted at a time.
//   out_chan carries year, month, day, hour, minute and second. The result
//            sits in an output register, so a new input word is taken while
//            an earlier result still waits for the receiver.
//   cfg_we / cfg_data write base_year (12 bits); write only while idle.
// Sequence: after the word is taken, the sequencer reduces base_year modulo
//   400, runs the day, hour and minute divisions (a quotient step and a
//   remainder step each), consumes whole years (at most 136) and whole months
//   (at most 11), then hands off; the year loop sets most of the time. A new
//   word can be taken from the cycle after the handoff.
// Reset: the sequencer returns to step zero, the output goes invalid and
//   base_year returns to 2000.
// Stall: when the receiver holds ready low, the finished result holds in the
//   output register; the sequencer waits at its last step until it is free.
module seconds_to_calendar_date_core (
  input  logic                     clk,
  input  logic                     rst_n,
  scd_in_if.sink                   in_chan,
  scd_out_if.source                out_chan,
  input  logic                     cfg_we,
  input  logic [scd_pkg::YearW-1:0] cfg_data
);

  // Sequencer state
  logic [scd_pkg::PcW-1:0]   pc_r, pc_nxt;
  scd_pkg::ctrl_t            ctrl;
  scd_pkg::div_const_t       dc;
  logic                      done;

  // Datapath registers
  logic [scd_pkg::SecondsW-1:0] acc_r, acc_nxt;    // dividend, then remainder
  logic [scd_pkg::DaysW-1:0]    quo_r, quo_nxt;    // quotient of the division in work
  logic [scd_pkg::DaysW-1:0]    days_r, days_nxt;
  logic [scd_pkg::YearW-1:0]    year_r, year_nxt;
  logic [scd_pkg::YearW-1:0]    m400_r, m400_nxt;  // true year modulo 400
  logic [3:0]                   month_r, month_nxt;
  logic [4:0]                   hour_r, hour_nxt;
  logic [5:0]                   min_r, min_nxt;

  logic [scd_pkg::YearW-1:0]    base_year_r;
  logic                         out_valid_r, out_valid_nxt;
  scd_pkg::out_word_t           out_data_r, out_data_nxt;

  logic [scd_pkg::SecondsW-1:0] acc_sh;
  logic [scd_pkg::MulAW-1:0]    mul_a;
  logic [scd_pkg::ProdW-1:0]    prod;
  logic [scd_pkg::ProdW-1:0]    prod_sh;
  logic [31:0]                  back;
  logic                         leap;
  logic [8:0]                   diy;
  logic [4:0]                   dim;

  assign ctrl = scd_pkg::prog_rom(pc_r);
  assign dc   = scd_pkg::div_const(ctrl.dsel);

  // Gregorian rule on the year modulo 400: low two bits give modulo 4.
  assign leap = (m400_r == 12'd0) ||
                ((m400_r != 12'd100) && (m400_r != 12'd200) &&
                 (m400_r != 12'd300) && (m400_r[1:0] == 2'd0));
  assign diy  = leap ? 9'd366 : 9'd365;
  assign dim  = scd_pkg::days_in_month(leap, month_r);

  // Quotient by rounded-up reciprocal: pre-shift, multiply, post-shift
  assign acc_sh  = acc_r >> dc.pre;
  assign mul_a   = acc_sh[scd_pkg::MulAW-1:0];
  assign prod    = {{scd_pkg::RecipW{1'b0}}, mul_a} * {{scd_pkg::MulAW{1'b0}}, dc.recip};
  assign prod_sh = prod >> dc.post;

  // Multiply the quotient back to strip it from the dividend
  assign back = {16'd0, quo_r} * {15'd0, dc.dvsr};

  assign in_chan.ready  = (ctrl.op == scd_pkg::OP_WAIT);
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  always_comb begin
    acc_nxt       = acc_r;
    quo_nxt       = quo_r;
    days_nxt      = days_r;
    year_nxt      = year_r;
    m400_nxt      = m400_r;
    month_nxt     = month_r;
    hour_nxt      = hour_r;
    min_nxt       = min_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    done          = 1'b0;

    unique case (ctrl.op)
      scd_pkg::OP_WAIT: begin
        // Load the word and prime every loop
        if (in_chan.valid) begin
          done      = 1'b1;
          acc_nxt   = in_chan.data.seconds;
          year_nxt  = base_year_r;
          m400_nxt  = base_year_r;
          month_nxt = '0;
        end
      end
      scd_pkg::OP_MODY: begin
        if (m400_r >= scd_pkg::GREG_CYCLE) begin
          m400_nxt = m400_r - scd_pkg::GREG_CYCLE;
        end else begin
          done = 1'b1;
        end
      end
      scd_pkg::OP_DIVQ: begin
        done    = 1'b1;
        quo_nxt = prod_sh[scd_pkg::DaysW-1:0];
      end
      scd_pkg::OP_DIVR: begin
        // Keep the remainder for the next division and commit the quotient
        done    = 1'b1;
        acc_nxt = acc_r - back;
        unique case (ctrl.dsel)
          scd_pkg::DSEL_DAY:  days_nxt = quo_r;
          scd_pkg::DSEL_HOUR: hour_nxt = quo_r[4:0];
          scd_pkg::DSEL_MIN:  min_nxt  = quo_r[5:0];
          default:            days_nxt = days_r;
        endcase
      end
      scd_pkg::OP_YEAR: begin
        if (days_r >= {7'd0, diy}) begin
          days_nxt = days_r - {7'd0, diy};
          year_nxt = year_r + 12'd1;
          m400_nxt = (m400_r == scd_pkg::GREG_LAST) ? 12'd0 : m400_r + 12'd1;
        end else begin
          done = 1'b1;
        end
      end
      scd_pkg::OP_MONTH: begin
        if ((month_r < scd_pkg::LAST_MONTH) && (days_r >= {11'd0, dim})) begin
          days_nxt  = days_r - {11'd0, dim};
          month_nxt = month_r + 4'd1;
        end else begin
          done = 1'b1;
        end
      end
      scd_pkg::OP_OUT: begin
        // Hand off once the output register is free
        if (!out_valid_r || out_chan.ready) begin
          done          = 1'b1;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{year:   year_r,
                            month:  month_r,
                            day:    days_r[4:0],
                            hour:   hour_r,
                            minute: min_r,
                            second: acc_r[5:0]};
        end
      end
      default: done = 1'b0;
    endcase

    if (done) begin
      pc_nxt = ctrl.last ? '0 : pc_r + 4'd1;
    end else begin
      pc_nxt = pc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= '0;
      out_valid_r <= 1'b0;
      base_year_r <= scd_pkg::BASE_YEAR_RESET;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) base_year_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    quo_r      <= quo_nxt;
    days_r     <= days_nxt;
    year_r     <= year_nxt;
    m400_r     <= m400_nxt;
    month_r    <= month_nxt;
    hour_r     <= hour_nxt;
    min_r      <= min_nxt;
    out_data_r <= out_data_nxt;
  end

  // A result never leaves with a field out of calendar range
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.data.month <= 4'd11) && (out_chan.data.day <= 5'd30) &&
                       (out_chan.data.hour <= 5'd23) && (out_chan.data.minute <= 6'd59) &&
                       (out_chan.data.second <= 6'd59))
    else $error("result field out of range");

  // The year loop runs only on a reduced year modulo 400
  a_m400: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == scd_pkg::OP_YEAR) |-> (m400_r < scd_pkg::GREG_CYCLE))
    else $error("year modulo 400 not reduced");

  // An accepted word starts the program at its second step
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> (pc_r == 4'd1))
    else $error("sequencer did not advance after input");

endmodule

/* verif/testbench.sv */
// Self-checking bench for seconds_to_calendar_date_core: a queue-fed driver,
// a cycle-accurate monitor and a behavioral date predictor.
// Depends on scd_pkg, scd_in_if, scd_out_if and the core itself.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DaySecs     = 86400;
  localparam int unsigned HourSecs    = 3600;
  localparam int unsigned MinSecs     = 60;
  localparam int unsigned ResetCycles = 5;
  // Give the tail of the slowest conversion some slack.
  localparam int unsigned SettleCycles = 300;
  // Roughly 1670 words, each at most the slowest conversion plus stalls, taken several times.
  localparam int unsigned CycleLimit   = 2_000_000;
  localparam int unsigned RandomRuns   = 16;
  localparam int unsigned WordsPerRun  = 103;

  // Month lengths of a common year, January first.
  localparam int unsigned MonthLen [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  // Kinds of work that the stimulus queue carries.
  typedef enum logic [1:0] {
    ENT_WORD,   // present one seconds word
    ENT_BASE,   // drain, then write base_year
    ENT_DRAIN,  // hold the sender until every result is back
    ENT_PACE    // switch idle and stall percentages
  } entry_kind_t;

  typedef struct {
    entry_kind_t kind;
    logic [31:0] value;
  } entry_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic                      cfg_we   = 1'b0;
  logic [scd_pkg::YearW-1:0] cfg_data = scd_pkg::BASE_YEAR_RESET;

  scd_in_if  in_chan ();
  scd_out_if out_chan ();

  seconds_to_calendar_date_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  entry_t             pending_words [$];
  scd_pkg::out_word_t expected_dates [$];
  int unsigned words_sent     = 0;
  int unsigned results_seen   = 0;
  int unsigned base_writes    = 0;
  int unsigned failures       = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic [scd_pkg::YearW-1:0] model_base = scd_pkg::BASE_YEAR_RESET;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Calendar arithmetic
  // ---------------------------------------------------------------------------

  // Gregorian rule, applied to every year including year zero.
  function automatic logic leap_year(input int unsigned yr);
    if (yr % 400 == 0) return 1'b1;
    if (yr % 100 == 0) return 1'b0;
    return (yr % 4 == 0);
  endfunction

  function automatic int unsigned year_length(input int unsigned yr);
    return leap_year(yr) ? 366 : 365;
  endfunction

  function automatic int unsigned month_length(input logic leap, input int unsigned mon);
    if (mon == scd_pkg::FEBRUARY && leap) return 29;
    return MonthLen[mon];
  endfunction

  // Expected date for one seconds word under the given base year: peel off
  // whole years, then whole months of the reached year. The year wraps at
  // twelve bits.
  function automatic scd_pkg::out_word_t predict_date(input logic [31:0] secs,
                                                      input logic [scd_pkg::YearW-1:0] base);
    int unsigned        tod;
    int unsigned        days;
    int unsigned        yr;
    int unsigned        mon;
    logic               leap;
    scd_pkg::out_word_t d;
    tod  = secs % DaySecs;
    days = secs / DaySecs;
    yr   = base;
    mon  = 0;
    while (days >= year_length(yr)) begin
      days -= year_length(yr);
      yr++;
    end
    leap = leap_year(yr);
    while (mon < 11 && days >= month_length(leap, mon)) begin
      days -= month_length(leap, mon);
      mon++;
    end
    d.year   = yr[scd_pkg::YearW-1:0];
    d.month  = mon[3:0];
    d.day    = days[4:0];
    d.hour   = 5'(tod / HourSecs);
    d.minute = 6'((tod % HourSecs) / MinSecs);
    d.second = 6'(tod % MinSecs);
    return d;
  endfunction

  // Seconds count of midnight on a given day: yrs whole years past the base,
  // then mon whole months, then day whole days. Used to aim at boundaries.
  function automatic longint unsigned seconds_at(input int unsigned base,
                                                 input int unsigned yrs,
                                                 input int unsigned mon,
                                                 input int unsigned day);
    longint unsigned days;
    int unsigned     yr;
    int unsigned     m;
    days = 0;
    for (yr = base; yr < base + yrs; yr++) days += year_length(yr);
    for (m = 0; m < mon; m++) days += month_length(leap_year(base + yrs), m);
    return (days + day) * DaySecs;
  endfunction

  // Random seconds word: four draws in ten full-range, the rest aimed at the first
  // few years, at month and year edges, and at the top of the range.
  function automatic logic [31:0] random_seconds(input int unsigned base);
    longint unsigned t;
    int unsigned     yrs;
    int unsigned     mon;
    int unsigned     pick;
    pick = $urandom_range(9);
    if (pick <= 3) return $urandom();
    if (pick <= 5) return $urandom_range(4 * 366 * DaySecs - 1);
    if (pick == 9) return 32'hFFFF_FFFF - $urandom_range(400 * DaySecs);
    yrs = $urandom_range(135);
    mon = $urandom_range(11);
    t = seconds_at(base, yrs, mon,
                   $urandom_range(1) ? 0 : month_length(leap_year(base + yrs), mon) - 1);
    case ($urandom_range(2))
      0: t = (t > 0) ? t - 1 : t;
      1: t = t + DaySecs - 1;
      default: t = t + $urandom_range(DaySecs - 1);
    endcase
    if (t > 64'hFFFF_FFFF) return $urandom();
    return t[31:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus queue
  // ---------------------------------------------------------------------------

  task automatic add_word(input longint unsigned secs);
    pending_words.push_back('{kind: ENT_WORD, value: secs[31:0]});
  endtask

  task automatic add_base(input int unsigned yr);
    pending_words.push_back('{kind: ENT_BASE, value: yr});
  endtask

  task automatic add_pace(input int unsigned idle_pct, input int unsigned stall_pct);
    pending_words.push_back('{kind: ENT_PACE, value: {16'd0, 8'(idle_pct), 8'(stall_pct)}});
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present one word at a time, pause for configuration and drains
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : feed_words
    logic                      next_valid;
    scd_pkg::in_word_t         next_word;
    logic                      next_we;
    logic [scd_pkg::YearW-1:0] next_cfg;
    entry_t                    head;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      in_chan.data  <= '0;
      cfg_we        <= 1'b0;
      words_sent    <= 0;
    end else begin
      next_valid = in_chan.valid;
      next_word  = in_chan.data;
      next_we    = 1'b0;
      next_cfg   = cfg_data;
      // Retire the word that the core took at this edge.
      if (in_chan.valid && in_chan.ready) begin
        next_valid = 1'b0;
        words_sent <= words_sent + 1;
      end
      if (!next_valid && pending_words.size() != 0) begin
        head = pending_words[0];
        case (head.kind)
          ENT_WORD: begin
            // Drop this cycle at the sender's idle rate; otherwise present.
            if ($urandom_range(99) >= send_idle_pct) begin
              next_valid        = 1'b1;
              next_word.seconds = head.value;
              void'(pending_words.pop_front());
            end
          end
          ENT_PACE: begin
            send_idle_pct  <= head.value[15:8];
            recv_stall_pct <= head.value[7:0];
            void'(pending_words.pop_front());
          end
          default: begin
            // Hold until the core is empty: nothing in flight, every result back.
            if (!in_chan.valid && results_seen == words_sent) begin
              if (head.kind == ENT_BASE) begin
                next_we  = 1'b1;
                next_cfg = head.value[scd_pkg::YearW-1:0];
              end
              void'(pending_words.pop_front());
            end
          end
        endcase
      end
      in_chan.valid <= next_valid;
      in_chan.data  <= next_word;
      cfg_we        <= next_we;
      cfg_data      <= next_cfg;
    end
  end

  // Receiver: stall at the current rate.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: track base_year, predict on every accepted word, check results
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin : check_dates
    scd_pkg::out_word_t want;
    scd_pkg::out_word_t got;
    if (!rst_n) begin
      model_base = scd_pkg::BASE_YEAR_RESET;
      results_seen <= 0;
    end else begin
      if (cfg_we) begin
        model_base = cfg_data;
        base_writes++;
      end
      if (in_chan.valid && in_chan.ready)
        expected_dates.push_back(predict_date(in_chan.data.seconds, model_base));
      if (out_chan.valid && out_chan.ready) begin
        got = out_chan.data;
        if (expected_dates.size() == 0) begin
          $error("unexpected result word: year %0d month %0d day %0d", got.year, got.month,
                 got.day);
          failures++;
        end else begin
          want = expected_dates.pop_front();
          check_field("year",   want.year,   got.year);
          check_field("month",  want.month,  got.month);
          check_field("day",    want.day,    got.day);
          check_field("hour",   want.hour,   got.hour);
          check_field("minute", want.minute, got.minute);
          check_field("second", want.second, got.second);
        end
        results_seen <= results_seen + 1;
      end
    end
  end

  // Watchdog: abandon a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("seconds_to_calendar_date_core verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : run_test
    int unsigned run_bases [8];
    int unsigned fill_base;
    int unsigned run;
    int unsigned pace;
    int unsigned n;
    in_chan.valid  = 1'b0;
    in_chan.data   = '0;
    out_chan.ready = 1'b0;
    run_bases = '{1900, 2100, 0, 4095, 1970, 3960, 2000, $urandom_range(4095)};

    // Directed words under the reset base year, 2000 (a century leap year).
    add_word(0);
    add_word(1);
    add_word(59);
    add_word(60);
    add_word(3599);
    add_word(3600);
    add_word(DaySecs - 1);
    add_word(DaySecs);
    add_word(seconds_at(2000, 0, 1, 28) - 1);    // last second of Feb 28
    add_word(seconds_at(2000, 0, 1, 28));        // Feb 29 of a leap year
    add_word(seconds_at(2000, 0, 2, 0));         // March 1
    add_word(seconds_at(2000, 0, 7, 30));        // August 31, second 31-day month in a row
    add_word(seconds_at(2000, 1, 0, 0) - 1);     // Dec 31 23:59:59
    add_word(seconds_at(2000, 1, 0, 0));         // next New Year
    add_word(32'h8000_0000);
    add_word(32'hFFFF_FFFF);
    // A century year that is not leap: February ends on the 28th.
    add_base(1900);
    add_word(seconds_at(1900, 0, 2, 0) - 1);
    add_word(seconds_at(1900, 0, 2, 0));
    add_base(2100);
    add_word(seconds_at(2100, 0, 2, 0) - 1);
    // Year zero counts as leap.
    add_base(0);
    add_word(seconds_at(0, 0, 1, 28));
    // Top of the register: the year field wraps past 4095.
    add_base(4095);
    add_word(seconds_at(4095, 1, 0, 0));
    add_word(32'hFFFF_FFFF);

    // Random runs: a new base year every other run, pacing rotated through
    // free flow, sender idling, receiver stalling and both.
    for (run = 0; run < RandomRuns; run++) begin
      if (run % 2 == 0) begin
        fill_base = run_bases[run / 2];
        add_base(fill_base);
      end
      pace = (run + run / 2) % 4;
      case (pace)
        0: add_pace(0, 0);
        1: add_pace(49, 0);
        2: add_pace(0, 49);
        default: add_pace(12, 12);
      endcase
      for (n = 0; n < WordsPerRun; n++) begin
        // Hold the sender once mid-run until the core has fully drained.
        if (run == 5 && n == WordsPerRun / 2)
          pending_words.push_back('{kind: ENT_DRAIN, value: '0});
        add_word(random_seconds(fill_base));
      end
    end

    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    // Advance until every word is taken and every result is back.
    while (pending_words.size() != 0 || in_chan.valid || results_seen != words_sent)
      @(negedge clk);
    repeat (SettleCycles) @(posedge clk);

    if (expected_dates.size() != 0) begin
      $error("%0d expected dates never arrived", expected_dates.size());
      failures++;
    end
    $display("Converted %0d seconds words under %0d base_year writes, paced free, sender-idle,",
             results_seen, base_writes);
    $display("receiver-stalled and mixed; %0d field mismatches seen.", failures);
    if (failures == 0) begin
      $display("seconds_to_calendar_date_core verification clean");
    end else begin
      $display("seconds_to_calendar_date_core verification failed");
    end
    $finish;
  end

endmodule
